// ===== design/wsd_pkg.sv =====
// Shared types and constants of the WebSocket frame deframer.
package wsd_pkg;

    localparam int LENGTH_WIDTH_DEF = 64;
    localparam int QUEUE_DEPTH_DEF  = 4;

    localparam logic [31:0] MAX_LEN_RESET = 32'd4194304;
    localparam logic [3:0]  OPCODE_CLOSE  = 4'd8;
    localparam logic [6:0]  LEN7_EXT2     = 7'd126;
    localparam logic [6:0]  LEN7_EXT8     = 7'd127;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_CLOSE = 2'd2,
        KIND_LONG  = 2'd3
    } t_kind;

    typedef enum logic [5:0] {
        PH_HDR0 = 6'b000001,
        PH_HDR1 = 6'b000010,
        PH_EXT2 = 6'b000100,
        PH_EXT8 = 6'b001000,
        PH_KEY  = 6'b010000,
        PH_DATA = 6'b100000
    } t_phase;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic [7:0] key;
        logic       last;
    } t_beat;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] payload;
        logic       last;
    } t_result;

endpackage

// ===== design/wsd_parser.sv =====
// Front part: header parser that turns payload bytes and frame events into result beats.
module wsd_parser #(
    parameter int LENGTH_WIDTH = wsd_pkg::LENGTH_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_byte,
    input  logic          i_cfg_we,
    input  logic [31:0]   i_cfg_data,
    output logic          o_wr,
    output wsd_pkg::t_beat o_beat
);

    localparam int LW = LENGTH_WIDTH;
    localparam int CW = (LW > 32) ? LW : 32;

    wsd_pkg::t_phase   r_phase, n_phase;
    logic [3:0]        r_opcode, n_opcode;
    logic              r_masked, n_masked;
    logic [LW-1:0]     r_len, n_len;
    logic [2:0]        r_hcnt, n_hcnt;
    logic [31:0]       r_key, n_key;
    logic [1:0]        r_midx, n_midx;
    logic [LW-1:0]     r_rem, n_rem;
    logic              r_stopped, n_stopped;
    logic [31:0]       r_max_len;

    logic [LW-1:0]     len_val;
    logic [LW-1:0]     rem_dec;
    logic              len_done;
    logic              begin_pl;
    logic              over;

    always_comb begin
        n_phase   = r_phase;
        n_opcode  = r_opcode;
        n_masked  = r_masked;
        n_len     = r_len;
        n_hcnt    = r_hcnt;
        n_key     = r_key;
        n_midx    = r_midx;
        n_rem     = r_rem;
        n_stopped = r_stopped;
        o_wr      = 1'b0;
        o_beat    = '0;
        len_val   = r_len;
        len_done  = 1'b0;
        begin_pl  = 1'b0;
        rem_dec   = (r_rem != '0) ? r_rem - LW'(1) : r_rem;
        if (i_valid && !r_stopped) begin
            unique case (r_phase)
                wsd_pkg::PH_HDR1: begin
                    n_masked = i_byte[7];
                    n_hcnt   = '0;
                    n_len    = '0;
                    if (i_byte[6:0] == wsd_pkg::LEN7_EXT2) begin
                        n_phase = wsd_pkg::PH_EXT2;
                    end else if (i_byte[6:0] == wsd_pkg::LEN7_EXT8) begin
                        n_phase = wsd_pkg::PH_EXT8;
                    end else begin
                        len_val  = LW'(i_byte[6:0]);
                        len_done = 1'b1;
                    end
                end
                wsd_pkg::PH_EXT2, wsd_pkg::PH_EXT8: begin
                    if (r_len[LW-1 -: 8] != 8'd0) begin
                        len_val = '1;
                    end else begin
                        len_val = {r_len[LW-9:0], i_byte};
                    end
                    n_len  = len_val;
                    n_hcnt = r_hcnt + 3'd1;
                    if ((r_phase == wsd_pkg::PH_EXT2 && n_hcnt == 3'd2) ||
                        (r_phase == wsd_pkg::PH_EXT8 && n_hcnt == 3'd0)) begin
                        len_done = 1'b1;
                    end
                end
                wsd_pkg::PH_KEY: begin
                    n_key  = {r_key[23:0], i_byte};
                    n_hcnt = r_hcnt + 3'd1;
                    if (n_hcnt == 3'd4) begin
                        begin_pl = 1'b1;
                    end
                end
                wsd_pkg::PH_DATA: begin
                    n_midx      = r_midx + 2'd1;
                    n_rem       = rem_dec;
                    o_wr        = 1'b1;
                    o_beat.kind = wsd_pkg::KIND_DATA;
                    o_beat.data = i_byte;
                    o_beat.key  = r_key[{~r_midx, 3'b000} +: 8];
                    o_beat.last = (rem_dec == '0);
                    if (rem_dec == '0) begin
                        n_phase = wsd_pkg::PH_HDR0;
                    end
                end
                default: begin
                    n_opcode = i_byte[3:0];
                    n_phase  = wsd_pkg::PH_HDR1;
                end
            endcase
        end

        over = CW'(len_val) > CW'(r_max_len);

        if (len_done) begin
            n_len  = len_val;
            n_hcnt = '0;
            if (r_opcode == wsd_pkg::OPCODE_CLOSE) begin
                n_stopped   = 1'b1;
                o_wr        = 1'b1;
                o_beat.kind = wsd_pkg::KIND_CLOSE;
            end else if (over) begin
                n_stopped   = 1'b1;
                o_wr        = 1'b1;
                o_beat.kind = wsd_pkg::KIND_LONG;
            end else if (n_masked) begin
                n_key   = '0;
                n_phase = wsd_pkg::PH_KEY;
            end else begin
                n_key    = '0;
                begin_pl = 1'b1;
            end
        end

        if (begin_pl) begin
            n_midx = '0;
            n_rem  = len_val;
            n_hcnt = '0;
            if (len_val == '0) begin
                n_phase     = wsd_pkg::PH_HDR0;
                o_wr        = 1'b1;
                o_beat.kind = wsd_pkg::KIND_EMPTY;
                o_beat.last = 1'b1;
            end else begin
                n_phase = wsd_pkg::PH_DATA;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= wsd_pkg::PH_HDR0;
            r_opcode  <= '0;
            r_masked  <= 1'b0;
            r_len     <= '0;
            r_hcnt    <= '0;
            r_key     <= '0;
            r_midx    <= '0;
            r_rem     <= '0;
            r_stopped <= 1'b0;
            r_max_len <= wsd_pkg::MAX_LEN_RESET;
        end else begin
            r_phase   <= n_phase;
            r_opcode  <= n_opcode;
            r_masked  <= n_masked;
            r_len     <= n_len;
            r_hcnt    <= n_hcnt;
            r_key     <= n_key;
            r_midx    <= n_midx;
            r_rem     <= n_rem;
            r_stopped <= n_stopped;
            if (i_cfg_we) begin
                r_max_len <= i_cfg_data;
            end
        end
    end

    a_stop_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |=> r_stopped)
        else $error("stopped flag cleared without reset");

    a_stop_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |-> !o_wr)
        else $error("beat produced after an error");

    a_error_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_wr && (o_beat.kind == wsd_pkg::KIND_CLOSE ||
                  o_beat.kind == wsd_pkg::KIND_LONG)) |=> r_stopped)
        else $error("error beat did not stop the parser");

endmodule

// ===== design/wsd_queue.sv =====
// Short first-word-fall-through queue of classified beats between parser and output stage.
module wsd_queue #(
    parameter int DEPTH = wsd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  wsd_pkg::t_beat i_beat,
    input  logic           i_rd,
    output wsd_pkg::t_beat o_beat,
    output logic           o_full,
    output logic           o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    wsd_pkg::t_beat   r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_en, rd_en;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_beat  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
            end
            if (rd_en) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
            end
            case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr && o_full))
        else $error("beat written into a full queue");

endmodule

// ===== design/wsd_unmask.sv =====
// Back part: unmasks queued beats into the output register presented to the receiver.
module wsd_unmask (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  wsd_pkg::t_beat   i_q_beat,
    output logic             o_q_rd,
    input  logic             i_pop,
    output logic             o_empty,
    output wsd_pkg::t_result o_result
);

    logic             r_valid;
    wsd_pkg::t_result r_result;

    assign o_q_rd   = !i_q_empty && (!r_valid || i_pop);
    assign o_empty  = !r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_rd) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_result.kind    <= i_q_beat.kind;
            r_result.payload <= i_q_beat.data ^ i_q_beat.key;
            r_result.last    <= i_q_beat.last;
        end
    end

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_pop) |=> (r_valid && $stable(r_result)))
        else $error("output beat changed while stalled");

endmodule

// ===== design/websocket_frame_deframer.sv =====
// Top level of the receive-side WebSocket frame deframer.
//
// Input channel: one received stream byte per beat on i_rx_byte, taken when
// push is high and full is low. Result channel: while empty is low the oldest
// result sits on o_kind, o_payload_byte and o_last_of_frame, and is taken when
// pop is high. Configuration channel: i_cfg_valid/o_cfg_ready writes the
// maximum payload length; o_cfg_ready is always high.
// Throughput is one byte per cycle while full is low; the parser updates its
// header state as each byte is taken. A result reaches the output ports via
// the queue and then the output register: the parser writes the queue at the
// edge that takes the byte, and the queue feeds the output register once it is free.
// Header bytes give no result unless one ends a close, over-limit or empty header.
// When the receiver stalls, results pile up in the beat queue (QUEUE_DEPTH
// entries) plus the output register; full rises once the queue is full.
// Reset (synchronous, active low) empties the queue, returns the parser to the
// first header byte, clears the error stop and restores the limit to 4 MiB.
// After a close or over-limit error every further byte is taken and dropped.
module websocket_frame_deframer #(
    parameter int LENGTH_WIDTH = wsd_pkg::LENGTH_WIDTH_DEF,
    parameter int QUEUE_DEPTH  = wsd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_payload_byte,
    output logic        o_last_of_frame,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    logic             in_beat;
    logic             p_wr;
    wsd_pkg::t_beat   p_beat;
    wsd_pkg::t_beat   q_beat;
    logic             q_rd;
    logic             q_empty;
    wsd_pkg::t_result result;

    assign o_cfg_ready = 1'b1;
    assign in_beat     = push && !full;

    wsd_parser #(
        .LENGTH_WIDTH(LENGTH_WIDTH)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (in_beat),
        .i_byte     (i_rx_byte),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_wr       (p_wr),
        .o_beat     (p_beat)
    );

    wsd_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (p_wr),
        .i_beat  (p_beat),
        .i_rd    (q_rd),
        .o_beat  (q_beat),
        .o_full  (full),
        .o_empty (q_empty)
    );

    wsd_unmask u_unmask (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_beat  (q_beat),
        .o_q_rd    (q_rd),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (result)
    );

    assign o_kind          = result.kind;
    assign o_payload_byte  = result.payload;
    assign o_last_of_frame = result.last;

endmodule
